// ----- sv/circle_elastic_collision_resolve_top_assert.svh -----
// assertion macros shared by the collision resolver modules
`ifndef CIRCLE_ELASTIC_COLLISION_RESOLVE_TOP_ASSERT_SVH
`define CIRCLE_ELASTIC_COLLISION_RESOLVE_TOP_ASSERT_SVH

// condition must never hold outside reset
`define CECR_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CECR_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CECR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cecr_pkg.sv -----
// shared types, constants and helpers for the collision resolver
package cecr_pkg;

    localparam int FRAC_BITS = 16;
    // quotient and mass share width, signed normal width
    localparam int QW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 2;
    // divider datapath width, holds twice the largest mass sum
    localparam int DIV_W = 34;
    localparam int DIV_STEPS = QW;

    localparam logic [30:0] HUNDREDTH = 31'(((1 << FRAC_BITS) + 50) / 100);
    localparam logic [QW-1:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [QW-1:0] HALF = {2'b01, {(FRAC_BITS-1){1'b0}}};

    localparam int MID_DEPTH = 32;
    localparam int MID_AW = 5;
    localparam int OUT_DEPTH = 8;
    localparam int OUT_AW = 3;

    typedef struct packed {
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic [15:0]        first_radius;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic [15:0]        second_radius;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [30:0]        centre_distance;
        logic [30:0]        contact_distance;
    } in_t;

    typedef struct packed {
        logic               collided;
        logic signed [31:0] new_first_vel_x;
        logic signed [31:0] new_first_vel_y;
        logic signed [31:0] new_second_vel_x;
        logic signed [31:0] new_second_vel_y;
        logic signed [31:0] first_shift_x;
        logic signed [31:0] first_shift_y;
        logic signed [31:0] second_shift_x;
        logic signed [31:0] second_shift_y;
    } out_t;

    // classified pair handed from front to back
    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic [QW-1:0]      ratio1;
        logic [QW-1:0]      ratio2;
        logic signed [31:0] sep;
    } mid_t;

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647)
            y = 32'sh7fffffff;
        else if (x < -64'sd2147483648)
            y = 32'sh80000000;
        else
            y = x[31:0];
        return y;
    endfunction

endpackage

// ----- sv/cecr_div.sv -----
// pipelined restoring divider, one quotient bit per stage
module cecr_div (
    input  logic                          clk,
    input  logic [cecr_pkg::DIV_W-1:0]    rem_init,
    input  logic                          bit_init,
    input  logic [cecr_pkg::DIV_W-1:0]    den,
    output logic [cecr_pkg::QW-1:0]       quo
);

    logic [cecr_pkg::DIV_W-1:0] rem_reg [cecr_pkg::DIV_STEPS];
    logic [cecr_pkg::DIV_W-1:0] den_reg [cecr_pkg::DIV_STEPS];
    logic [cecr_pkg::QW-1:0]    quo_reg [cecr_pkg::DIV_STEPS];

    genvar k;
    for (k = 0; k < cecr_pkg::DIV_STEPS; k++)
    begin : g_step
        logic [cecr_pkg::DIV_W-1:0] r_in;
        logic [cecr_pkg::DIV_W-1:0] d_in;
        logic [cecr_pkg::QW-1:0]    q_in;
        logic                       b_in;
        logic [cecr_pkg::DIV_W:0]   trial;
        logic [cecr_pkg::DIV_W:0]   diff;
        logic                       take;

        // first stage takes the remainder seed and the one live numerator bit
        if (k == 0)
        begin : g_first
            assign r_in = rem_init;
            assign d_in = den;
            assign q_in = '0;
            assign b_in = bit_init;
        end
        else
        begin : g_next
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = quo_reg[k-1];
            assign b_in = 1'b0;
        end

        // trial subtract
        assign trial = {r_in, b_in};
        assign diff  = trial - {1'b0, d_in};
        assign take  = trial >= {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= take ? diff[cecr_pkg::DIV_W-1:0] : trial[cecr_pkg::DIV_W-1:0];
            den_reg[k] <= d_in;
            quo_reg[k] <= {q_in[cecr_pkg::QW-2:0], take};
        end
    end

    assign quo = quo_reg[cecr_pkg::DIV_STEPS-1];

endmodule

// ----- sv/cecr_front.sv -----
// front end: accepts pairs, forms the normal and mass shares, queues them
`include "circle_elastic_collision_resolve_top_assert.svh"

module cecr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cecr_pkg::in_t    item,
    input  logic             mid_pop,
    output logic             mid_empty,
    output cecr_pkg::mid_t   mid_data
);

    localparam int MID_AW_P1 = cecr_pkg::MID_AW + 1;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
        logic signed [31:0] sep;
        logic               negx;
        logic               negy;
        logic               bigx;
        logic               bigy;
        logic               zmass;
    } side_t;

    // request handshake and credit for the queue
    logic                 accept;
    logic                 pop_ok;
    logic [MID_AW_P1-1:0] credit_reg;
    logic [MID_AW_P1-1:0] credit_next;

    // first stage
    logic [30:0]        d_c;
    logic [31:0]        absx_c;
    logic [31:0]        absy_c;
    logic signed [31:0] diff_c;
    side_t              side_c;
    logic               s0_vld_reg;
    side_t              s0_side_reg;
    logic [30:0]        d_reg;
    logic [31:0]        absx_reg;
    logic [31:0]        absy_reg;
    logic [31:0]        m1_reg;
    logic [31:0]        m2_reg;
    logic [32:0]        msum_reg;

    // divider side pipe
    side_t side_reg [cecr_pkg::DIV_STEPS];
    logic [cecr_pkg::DIV_STEPS-1:0] vld_reg;
    logic [cecr_pkg::QW-1:0] qx;
    logic [cecr_pkg::QW-1:0] qy;
    logic [cecr_pkg::QW-1:0] q1;
    logic [cecr_pkg::QW-1:0] q2;

    // finishing stage
    side_t                       fin;
    logic [cecr_pkg::QW-1:0]     magx;
    logic [cecr_pkg::QW-1:0]     magy;
    cecr_pkg::mid_t              wr_data;
    logic                        wr_en;

    // queue storage
    cecr_pkg::mid_t       mem_reg [cecr_pkg::MID_DEPTH];
    logic [MID_AW_P1-1:0] wr_ptr_reg;
    logic [MID_AW_P1-1:0] rd_ptr_reg;

    assign full   = credit_reg == MID_AW_P1'(cecr_pkg::MID_DEPTH);
    assign accept = push && !full;
    assign pop_ok = mid_pop && !mid_empty;

    // credit counts pairs in flight plus pairs queued
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop_ok)
            credit_next = credit_reg + 1'b1;
        else if (!accept && pop_ok)
            credit_next = credit_reg - 1'b1;
    end

    // distance clamp, magnitudes and separation
    always_comb
    begin
        d_c = (item.centre_distance < cecr_pkg::HUNDREDTH) ? cecr_pkg::HUNDREDTH
                                                           : item.centre_distance;
        absx_c = item.offset_x[31] ? 32'(-item.offset_x) : item.offset_x;
        absy_c = item.offset_y[31] ? 32'(-item.offset_y) : item.offset_y;
        diff_c = $signed({1'b0, item.contact_distance}) - $signed({1'b0, d_c});
        side_c.v1x   = item.first_vel_x;
        side_c.v1y   = item.first_vel_y;
        side_c.v2x   = item.second_vel_x;
        side_c.v2y   = item.second_vel_y;
        side_c.sep   = (diff_c >>> 1) + $signed({1'b0, cecr_pkg::HUNDREDTH});
        side_c.negx  = item.offset_x[31];
        side_c.negy  = item.offset_y[31];
        side_c.bigx  = {1'b0, absx_c} >= {2'b00, d_c, 1'b0};
        side_c.bigy  = {1'b0, absy_c} >= {2'b00, d_c, 1'b0};
        side_c.zmass = (item.first_radius == '0) && (item.second_radius == '0);
    end

    always_ff @(posedge clk)
    begin
        s0_side_reg <= side_c;
        d_reg       <= d_c;
        absx_reg    <= absx_c;
        absy_reg    <= absy_c;
        m1_reg      <= 32'(item.first_radius) * 32'(item.first_radius);
        m2_reg      <= 32'(item.second_radius) * 32'(item.second_radius);
        msum_reg    <= 33'(32'(item.first_radius) * 32'(item.first_radius))
                     + 33'(32'(item.second_radius) * 32'(item.second_radius));
    end

    // normal and mass share dividers
    cecr_div u_div_nx (
        .clk      (clk),
        .rem_init (cecr_pkg::DIV_W'(absx_reg >> 1)),
        .bit_init (absx_reg[0]),
        .den      (cecr_pkg::DIV_W'(d_reg)),
        .quo      (qx)
    );

    cecr_div u_div_ny (
        .clk      (clk),
        .rem_init (cecr_pkg::DIV_W'(absy_reg >> 1)),
        .bit_init (absy_reg[0]),
        .den      (cecr_pkg::DIV_W'(d_reg)),
        .quo      (qy)
    );

    cecr_div u_div_r1 (
        .clk      (clk),
        .rem_init (cecr_pkg::DIV_W'(m2_reg >> 1)),
        .bit_init (m2_reg[0]),
        .den      (cecr_pkg::DIV_W'(msum_reg)),
        .quo      (q1)
    );

    cecr_div u_div_r2 (
        .clk      (clk),
        .rem_init (cecr_pkg::DIV_W'(m1_reg >> 1)),
        .bit_init (m1_reg[0]),
        .den      (cecr_pkg::DIV_W'(msum_reg)),
        .quo      (q2)
    );

    // side data follows the dividers
    always_ff @(posedge clk)
    begin
        side_reg[0] <= s0_side_reg;
        for (int k = 1; k < cecr_pkg::DIV_STEPS; k++)
            side_reg[k] <= side_reg[k-1];
    end

    // clamp and sign the normal, fix up the zero mass case
    always_comb
    begin
        fin  = side_reg[cecr_pkg::DIV_STEPS-1];
        magx = (fin.bigx || qx > cecr_pkg::UNIT) ? cecr_pkg::UNIT : qx;
        magy = (fin.bigy || qy > cecr_pkg::UNIT) ? cecr_pkg::UNIT : qy;
        wr_data.v1x    = fin.v1x;
        wr_data.v1y    = fin.v1y;
        wr_data.v2x    = fin.v2x;
        wr_data.v2y    = fin.v2y;
        wr_data.nx     = fin.negx ? -$signed({1'b0, magx}) : $signed({1'b0, magx});
        wr_data.ny     = fin.negy ? -$signed({1'b0, magy}) : $signed({1'b0, magy});
        wr_data.ratio1 = fin.zmass ? cecr_pkg::HALF : q1;
        wr_data.ratio2 = fin.zmass ? cecr_pkg::HALF : q2;
        wr_data.sep    = fin.sep;
        wr_en          = vld_reg[cecr_pkg::DIV_STEPS-1];
    end

    // queue write
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg[cecr_pkg::MID_AW-1:0]] <= wr_data;
    end

    assign mid_empty = wr_ptr_reg == rd_ptr_reg;
    assign mid_data  = mem_reg[rd_ptr_reg[cecr_pkg::MID_AW-1:0]];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            s0_vld_reg <= 1'b0;
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            s0_vld_reg <= accept;
            vld_reg    <= {vld_reg[cecr_pkg::DIV_STEPS-2:0], s0_vld_reg};
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop_ok)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    `CECR_ASSERT_NEVER(a_credit_bound, credit_reg > MID_AW_P1'(cecr_pkg::MID_DEPTH), "front credit overflow")
    `CECR_ASSERT_NEVER(a_queue_within_credit, MID_AW_P1'(wr_ptr_reg - rd_ptr_reg) > credit_reg, "queue holds more than credited")
    `CECR_ASSERT_NEXT(a_credit_rise, accept && !pop_ok, credit_reg == $past(credit_reg) + 1'b1, "credit missed a request")

endmodule

// ----- sv/cecr_back.sv -----
// back end: applies impulse and position shifts, holds finished results
`include "circle_elastic_collision_resolve_top_assert.svh"

module cecr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             mid_empty,
    output logic             mid_pop,
    input  cecr_pkg::mid_t   mid_data,
    output logic             empty,
    input  logic             pop,
    output cecr_pkg::out_t   result
);

    localparam int F    = cecr_pkg::FRAC_BITS;
    localparam int NW   = cecr_pkg::NW;
    localparam int PW   = 33 + NW;
    localparam int AW   = PW + 2 - F;
    localparam int RW   = cecr_pkg::QW + 1;
    localparam int PA   = AW + RW;
    localparam int PS   = 32 + RW;
    localparam int FA   = PA - F + NW;
    localparam int FS   = PS - F + NW;
    localparam int GA   = FA - F;
    localparam int GS   = FS - F;
    localparam int OAW1 = cecr_pkg::OUT_AW + 1;

    typedef struct packed {
        logic signed [31:0] v1x;
        logic signed [31:0] v1y;
        logic signed [31:0] v2x;
        logic signed [31:0] v2y;
    } vel_t;

    // credit and handshakes
    logic            out_pop_ok;
    logic [OAW1-1:0] cnt_reg;
    logic [OAW1-1:0] cnt_next;

    // stage 1: normal projection products
    logic signed [32:0]        dvx;
    logic signed [32:0]        dvy;
    logic                      b1_vld_reg;
    vel_t                      b1_vel_reg;
    logic signed [NW-1:0]      b1_nx_reg;
    logic signed [NW-1:0]      b1_ny_reg;
    logic signed [RW-1:0]      b1_r1_reg;
    logic signed [RW-1:0]      b1_r2_reg;
    logic signed [31:0]        b1_sep_reg;
    logic signed [PW-1:0]      b1_px_reg;
    logic signed [PW-1:0]      b1_py_reg;

    // stage 2: sign test and scaled normal speed
    logic signed [PW:0]        dsum;
    logic                      b2_vld_reg;
    vel_t                      b2_vel_reg;
    logic signed [NW-1:0]      b2_nx_reg;
    logic signed [NW-1:0]      b2_ny_reg;
    logic signed [RW-1:0]      b2_r1_reg;
    logic signed [RW-1:0]      b2_r2_reg;
    logic signed [31:0]        b2_sep_reg;
    logic                      b2_hit_reg;
    logic signed [AW-1:0]      b2_a_reg;

    // stage 3: mass share products
    logic                      b3_vld_reg;
    vel_t                      b3_vel_reg;
    logic signed [NW-1:0]      b3_nx_reg;
    logic signed [NW-1:0]      b3_ny_reg;
    logic                      b3_hit_reg;
    logic signed [PA-1:0]      b3_pa1_reg;
    logic signed [PA-1:0]      b3_pa2_reg;
    logic signed [PS-1:0]      b3_ps1_reg;
    logic signed [PS-1:0]      b3_ps2_reg;

    // stage 4: direction products
    logic signed [PA-F-1:0]    ta1;
    logic signed [PA-F-1:0]    ta2;
    logic signed [PS-F-1:0]    ts1;
    logic signed [PS-F-1:0]    ts2;
    logic                      b4_vld_reg;
    vel_t                      b4_vel_reg;
    logic                      b4_hit_reg;
    logic signed [FA-1:0]      b4_a1x_reg;
    logic signed [FA-1:0]      b4_a1y_reg;
    logic signed [FA-1:0]      b4_a2x_reg;
    logic signed [FA-1:0]      b4_a2y_reg;
    logic signed [FS-1:0]      b4_s1x_reg;
    logic signed [FS-1:0]      b4_s1y_reg;
    logic signed [FS-1:0]      b4_s2x_reg;
    logic signed [FS-1:0]      b4_s2y_reg;

    // result forming
    logic signed [GA-1:0]      g1x;
    logic signed [GA-1:0]      g1y;
    logic signed [GA-1:0]      g2x;
    logic signed [GA-1:0]      g2y;
    logic signed [GS-1:0]      h1x;
    logic signed [GS-1:0]      h1y;
    logic signed [GS-1:0]      h2x;
    logic signed [GS-1:0]      h2y;
    cecr_pkg::out_t            res;

    // result queue
    cecr_pkg::out_t  omem_reg [cecr_pkg::OUT_DEPTH];
    logic [OAW1-1:0] owr_reg;
    logic [OAW1-1:0] ord_reg;

    assign mid_pop    = !mid_empty && (cnt_reg != OAW1'(cecr_pkg::OUT_DEPTH));
    assign out_pop_ok = pop && !empty;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (mid_pop && !out_pop_ok)
            cnt_next = cnt_reg + 1'b1;
        else if (!mid_pop && out_pop_ok)
            cnt_next = cnt_reg - 1'b1;
    end

    // relative velocity along the normal
    assign dvx = 33'(mid_data.v2x) - 33'(mid_data.v1x);
    assign dvy = 33'(mid_data.v2y) - 33'(mid_data.v1y);

    always_ff @(posedge clk)
    begin
        b1_vel_reg <= '{mid_data.v1x, mid_data.v1y, mid_data.v2x, mid_data.v2y};
        b1_nx_reg  <= mid_data.nx;
        b1_ny_reg  <= mid_data.ny;
        b1_r1_reg  <= $signed({1'b0, mid_data.ratio1});
        b1_r2_reg  <= $signed({1'b0, mid_data.ratio2});
        b1_sep_reg <= mid_data.sep;
        b1_px_reg  <= dvx * mid_data.nx;
        b1_py_reg  <= dvy * mid_data.ny;
    end

    assign dsum = (PW+1)'(b1_px_reg) + (PW+1)'(b1_py_reg);

    always_ff @(posedge clk)
    begin
        b2_vel_reg <= b1_vel_reg;
        b2_nx_reg  <= b1_nx_reg;
        b2_ny_reg  <= b1_ny_reg;
        b2_r1_reg  <= b1_r1_reg;
        b2_r2_reg  <= b1_r2_reg;
        b2_sep_reg <= b1_sep_reg;
        b2_hit_reg <= dsum[PW];
        b2_a_reg   <= $signed({dsum[PW:F], 1'b0});
    end

    always_ff @(posedge clk)
    begin
        b3_vel_reg <= b2_vel_reg;
        b3_nx_reg  <= b2_nx_reg;
        b3_ny_reg  <= b2_ny_reg;
        b3_hit_reg <= b2_hit_reg;
        b3_pa1_reg <= b2_a_reg * b2_r1_reg;
        b3_pa2_reg <= b2_a_reg * b2_r2_reg;
        b3_ps1_reg <= b2_sep_reg * b2_r1_reg;
        b3_ps2_reg <= b2_sep_reg * b2_r2_reg;
    end

    assign ta1 = b3_pa1_reg[PA-1:F];
    assign ta2 = b3_pa2_reg[PA-1:F];
    assign ts1 = b3_ps1_reg[PS-1:F];
    assign ts2 = b3_ps2_reg[PS-1:F];

    always_ff @(posedge clk)
    begin
        b4_vel_reg <= b3_vel_reg;
        b4_hit_reg <= b3_hit_reg;
        b4_a1x_reg <= ta1 * b3_nx_reg;
        b4_a1y_reg <= ta1 * b3_ny_reg;
        b4_a2x_reg <= ta2 * b3_nx_reg;
        b4_a2y_reg <= ta2 * b3_ny_reg;
        b4_s1x_reg <= ts1 * b3_nx_reg;
        b4_s1y_reg <= ts1 * b3_ny_reg;
        b4_s2x_reg <= ts2 * b3_nx_reg;
        b4_s2y_reg <= ts2 * b3_ny_reg;
    end

    // final scaling, apply deltas and saturate
    assign g1x = b4_a1x_reg[FA-1:F];
    assign g1y = b4_a1y_reg[FA-1:F];
    assign g2x = b4_a2x_reg[FA-1:F];
    assign g2y = b4_a2y_reg[FA-1:F];
    assign h1x = b4_s1x_reg[FS-1:F];
    assign h1y = b4_s1y_reg[FS-1:F];
    assign h2x = b4_s2x_reg[FS-1:F];
    assign h2y = b4_s2y_reg[FS-1:F];

    always_comb
    begin
        res.collided = b4_hit_reg;
        if (b4_hit_reg)
        begin
            res.new_first_vel_x  = cecr_pkg::sat32(64'(b4_vel_reg.v1x) + 64'(g1x));
            res.new_first_vel_y  = cecr_pkg::sat32(64'(b4_vel_reg.v1y) + 64'(g1y));
            res.new_second_vel_x = cecr_pkg::sat32(64'(b4_vel_reg.v2x) - 64'(g2x));
            res.new_second_vel_y = cecr_pkg::sat32(64'(b4_vel_reg.v2y) - 64'(g2y));
            res.first_shift_x    = cecr_pkg::sat32(-64'(h1x));
            res.first_shift_y    = cecr_pkg::sat32(-64'(h1y));
            res.second_shift_x   = cecr_pkg::sat32(64'(h2x));
            res.second_shift_y   = cecr_pkg::sat32(64'(h2y));
        end
        else
        begin
            res.new_first_vel_x  = b4_vel_reg.v1x;
            res.new_first_vel_y  = b4_vel_reg.v1y;
            res.new_second_vel_x = b4_vel_reg.v2x;
            res.new_second_vel_y = b4_vel_reg.v2y;
            res.first_shift_x    = '0;
            res.first_shift_y    = '0;
            res.second_shift_x   = '0;
            res.second_shift_y   = '0;
        end
    end

    // result queue write
    always_ff @(posedge clk)
    begin
        if (b4_vld_reg)
            omem_reg[owr_reg[cecr_pkg::OUT_AW-1:0]] <= res;
    end

    assign empty  = owr_reg == ord_reg;
    assign result = omem_reg[ord_reg[cecr_pkg::OUT_AW-1:0]];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            b1_vld_reg <= 1'b0;
            b2_vld_reg <= 1'b0;
            b3_vld_reg <= 1'b0;
            b4_vld_reg <= 1'b0;
            owr_reg    <= '0;
            ord_reg    <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            b1_vld_reg <= mid_pop;
            b2_vld_reg <= b1_vld_reg;
            b3_vld_reg <= b2_vld_reg;
            b4_vld_reg <= b3_vld_reg;
            if (b4_vld_reg)
                owr_reg <= owr_reg + 1'b1;
            if (out_pop_ok)
                ord_reg <= ord_reg + 1'b1;
        end
    end

    `CECR_ASSERT_NEVER(a_out_credit_bound, cnt_reg > OAW1'(cecr_pkg::OUT_DEPTH), "result credit overflow")
    `CECR_ASSERT_NEVER(a_out_queue_within_credit, OAW1'(owr_reg - ord_reg) > cnt_reg, "result queue holds more than credited")
    `CECR_ASSERT_SAME(a_miss_no_shift, b4_vld_reg && !res.collided, res.first_shift_x == 0 && res.second_shift_y == 0, "separating pair got a shift")

endmodule

// ----- sv/circle_elastic_collision_resolve_top.sv -----
// Circle pair elastic collision resolver. Sustains one pair per clock unless
// full: the front end forms the contact normal and mass shares through four
// 17-stage pipelined dividers (one quotient bit per stage), queues classified
// pairs in a 32-entry buffer, and the back end applies impulse and separation
// shifts in a four-stage multiply pipeline into an 8-entry result queue. With
// empty queues a result can be taken once its request has passed the input
// stage, 17 divider stages, the buffer write, four back stages and the result
// queue write; full rises only when the queues are backed up by a stalled
// consumer. Values are Q15.16, results saturate to 32 bits.
module circle_elastic_collision_resolve_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  cecr_pkg::in_t    item,
    output logic             empty,
    input  logic             pop,
    output cecr_pkg::out_t   result
);

    logic           mid_pop;
    logic           mid_empty;
    cecr_pkg::mid_t mid_data;

    // normal and mass share stage with its queue
    cecr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .mid_pop   (mid_pop),
        .mid_empty (mid_empty),
        .mid_data  (mid_data)
    );

    // impulse and shift stage with result queue
    cecr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mid_empty (mid_empty),
        .mid_pop   (mid_pop),
        .mid_data  (mid_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule
